// ===== src/hbpt_pkg.sv =====
// shared types, constants and helpers for the hashed-base prime test core
// no dependencies
package hbpt_pkg;

	localparam logic [31:0] MIX_MUL = 32'h045D_9F3B;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_DECIDE,
		ST_RED,
		ST_TZ,
		ST_PSQ,
		ST_PMUL,
		ST_CHK,
		ST_SQ,
		ST_DONE
	} state_t;

	// 8-bit value mod 3: base-4 digits each weigh 1 mod 3
	function automatic logic [1:0] mod3_8(input logic [7:0] v);
		logic [3:0] s;
		logic [1:0] r;
		s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
		case (s)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
			default:                       r = 2'd2;
		endcase
		return r;
	endfunction

	// one msb-first remainder step for a small divisor
	function automatic logic [2:0] rem_step(input logic [2:0] r, input logic b,
			input logic [3:0] k);
		logic [3:0] t;
		t = {r, b};
		if (t >= k) begin
			t = t - k;
		end
		return t[2:0];
	endfunction

endpackage

// ===== src/hashed_base_prime_test_32_core.sv =====
// hashed-base single-base strong probable prime test on a 32-bit candidate
// depends on hbpt_pkg
//
// sequence: after the hash, candidates settled by trial division go straight to the result;
//   others go on through base reduction, the trailing zeros of n-1, the exponentiation,
//   the check and the squarings, with 33 to 63 modular products in all
// throughput: one candidate at a time, the next beat taken in the cycle after the result
//   registers; a bit-serial modular multiplier works one operand bit per cycle
// reset: arst_n clears the sequencer and the output valid at once
module hashed_base_prime_test_32_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] candidate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_prime,
	output logic [7:0]  mix_hash
);

	hbpt_pkg::state_t state_q, state_d;

	// candidate and trial division remainders
	logic [31:0] n_q;
	logic [31:0] sh_q;
	logic [2:0]  r3_q, r5_q, r7_q;

	// bit-serial hash multiplier
	logic [31:0] hh_q, ht_q, hc_q, hh_step;
	logic [7:0]  hash_q;

	// bit-serial modular multiplier
	logic [31:0] mm_a_q, mm_b_q, mm_r_q, mm_res;
	logic [4:0]  cnt_q;
	logic [33:0] mm_t, mm_t1, mm_m1, mm_m2;
	logic        cnt_last;

	// strong test state
	logic [31:0] base_q, d_q, e_q, acc_q;
	logic [4:0]  s_q, i_q, ecnt_q;
	logic        verdict_q;

	// output register
	logic        out_valid_q, is_prime_q;
	logic [7:0]  mix_hash_q;

	// decision from hash and trial division
	logic        dec_final, dec_val;
	logic [1:0]  base_sel;
	logic [31:0] base_val;
	logic        out_load, nm1_hit, one_hit, pow_last, sq_more;
	logic [31:0] nm1;

	assign cnt_last = (cnt_q == 5'd31);
	assign hh_step  = ht_q[0] ? hh_q + hc_q : hh_q;

	// r < m and b < m, so 2r + b < 3m: compare against m and 2m side by side
	always_comb begin
		mm_m1  = {2'b00, n_q};
		mm_m2  = {1'b0, n_q, 1'b0};
		mm_t   = {1'b0, mm_r_q, 1'b0} + (mm_a_q[31] ? {2'b00, mm_b_q} : 34'd0);
		if (mm_t >= mm_m2) begin
			mm_t1 = mm_t - mm_m2;
		end else if (mm_t >= mm_m1) begin
			mm_t1 = mm_t - mm_m1;
		end else begin
			mm_t1 = mm_t;
		end
		mm_res = mm_t1[31:0];
	end

	assign nm1      = n_q - 32'd1;
	assign nm1_hit  = (mm_res == nm1);
	assign one_hit  = (acc_q == 32'd1) || (acc_q == nm1);
	assign pow_last = (ecnt_q == 5'd31);
	assign sq_more  = ({1'b0, i_q} + 6'd1) < {1'b0, s_q};
	assign base_sel = hbpt_pkg::mod3_8(hash_q);

	always_comb begin
		case (base_sel)
			2'd0:    base_val = 32'd2;
			2'd1:    base_val = 32'd7;
			default: base_val = 32'd61;
		endcase
	end

	// small candidates and multiples of 2, 3, 5, 7 settle without the strong test
	always_comb begin
		dec_final = 1'b1;
		dec_val   = 1'b0;
		if (n_q < 32'd2) begin
			dec_val = 1'b0;
		end else if (n_q == 32'd2 || n_q == 32'd3 || n_q == 32'd5 || n_q == 32'd7) begin
			dec_val = 1'b1;
		end else if (!n_q[0] || r3_q == 3'd0 || r5_q == 3'd0 || r7_q == 3'd0) begin
			dec_val = 1'b0;
		end else begin
			dec_final = 1'b0;
		end
	end

	assign out_load = (state_q == hbpt_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hbpt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = hbpt_pkg::ST_HASH1;
				end
			end
			hbpt_pkg::ST_HASH1: begin
				if (cnt_last) begin
					state_d = hbpt_pkg::ST_HASH2;
				end
			end
			hbpt_pkg::ST_HASH2: begin
				if (cnt_last) begin
					state_d = hbpt_pkg::ST_DECIDE;
				end
			end
			hbpt_pkg::ST_DECIDE: begin
				state_d = dec_final ? hbpt_pkg::ST_DONE : hbpt_pkg::ST_RED;
			end
			hbpt_pkg::ST_RED: begin
				if (cnt_last) begin
					state_d = hbpt_pkg::ST_TZ;
				end
			end
			hbpt_pkg::ST_TZ: begin
				if (d_q[0]) begin
					state_d = hbpt_pkg::ST_PSQ;
				end
			end
			hbpt_pkg::ST_PSQ: begin
				if (cnt_last) begin
					if (e_q[31]) begin
						state_d = hbpt_pkg::ST_PMUL;
					end else if (pow_last) begin
						state_d = hbpt_pkg::ST_CHK;
					end
				end
			end
			hbpt_pkg::ST_PMUL: begin
				if (cnt_last) begin
					state_d = pow_last ? hbpt_pkg::ST_CHK : hbpt_pkg::ST_PSQ;
				end
			end
			hbpt_pkg::ST_CHK: begin
				if (one_hit || !({1'b0, i_q} < {1'b0, s_q})) begin
					state_d = hbpt_pkg::ST_DONE;
				end else begin
					state_d = hbpt_pkg::ST_SQ;
				end
			end
			hbpt_pkg::ST_SQ: begin
				if (cnt_last && (nm1_hit || !sq_more)) begin
					state_d = hbpt_pkg::ST_DONE;
				end
			end
			hbpt_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = hbpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hbpt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			hbpt_pkg::ST_IDLE: begin
				n_q   <= candidate;
				sh_q  <= candidate;
				r3_q  <= 3'd0;
				r5_q  <= 3'd0;
				r7_q  <= 3'd0;
				hh_q  <= 32'd0;
				ht_q  <= candidate ^ {16'd0, candidate[31:16]};
				hc_q  <= hbpt_pkg::MIX_MUL;
				cnt_q <= 5'd0;
			end
			hbpt_pkg::ST_HASH1: begin
				// trial division rides along, msb first
				r3_q  <= hbpt_pkg::rem_step(r3_q, sh_q[31], 4'd3);
				r5_q  <= hbpt_pkg::rem_step(r5_q, sh_q[31], 4'd5);
				r7_q  <= hbpt_pkg::rem_step(r7_q, sh_q[31], 4'd7);
				sh_q  <= {sh_q[30:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_last) begin
					hh_q <= 32'd0;
					ht_q <= hh_step ^ {16'd0, hh_step[31:16]};
					hc_q <= hbpt_pkg::MIX_MUL;
				end else begin
					hh_q <= hh_step;
					ht_q <= {1'b0, ht_q[31:1]};
					hc_q <= {hc_q[30:0], 1'b0};
				end
			end
			hbpt_pkg::ST_HASH2: begin
				cnt_q <= cnt_q + 5'd1;
				hh_q  <= hh_step;
				ht_q  <= {1'b0, ht_q[31:1]};
				hc_q  <= {hc_q[30:0], 1'b0};
				if (cnt_last) begin
					hash_q <= hh_step[7:0] ^ hh_step[23:16];
				end
			end
			hbpt_pkg::ST_DECIDE: begin
				verdict_q <= dec_val;
				// base mod n through the multiplier: base times one
				mm_a_q    <= base_val;
				mm_b_q    <= 32'd1;
				mm_r_q    <= 32'd0;
				cnt_q     <= 5'd0;
				d_q       <= n_q - 32'd1;
				s_q       <= 5'd0;
			end
			hbpt_pkg::ST_RED: begin
				cnt_q  <= cnt_q + 5'd1;
				mm_a_q <= {mm_a_q[30:0], 1'b0};
				mm_r_q <= mm_res;
				if (cnt_last) begin
					base_q <= mm_res;
				end
			end
			hbpt_pkg::ST_TZ: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[31:1]};
					s_q <= s_q + 5'd1;
				end else begin
					e_q    <= d_q;
					ecnt_q <= 5'd0;
					i_q    <= 5'd1;
					acc_q  <= 32'd1;
					mm_a_q <= 32'd1;
					mm_b_q <= 32'd1;
					mm_r_q <= 32'd0;
					cnt_q  <= 5'd0;
				end
			end
			hbpt_pkg::ST_PSQ, hbpt_pkg::ST_PMUL: begin
				cnt_q  <= cnt_q + 5'd1;
				mm_a_q <= {mm_a_q[30:0], 1'b0};
				mm_r_q <= mm_res;
				if (cnt_last) begin
					acc_q  <= mm_res;
					mm_r_q <= 32'd0;
					mm_a_q <= mm_res;
					if (state_q == hbpt_pkg::ST_PSQ && e_q[31]) begin
						mm_b_q <= base_q;
					end else begin
						// next exponent bit: square again
						mm_b_q <= mm_res;
						e_q    <= {e_q[30:0], 1'b0};
						ecnt_q <= ecnt_q + 5'd1;
					end
				end
			end
			hbpt_pkg::ST_CHK: begin
				mm_a_q <= acc_q;
				mm_b_q <= acc_q;
				mm_r_q <= 32'd0;
				cnt_q  <= 5'd0;
				if (one_hit) begin
					verdict_q <= 1'b1;
				end else begin
					verdict_q <= 1'b0;
				end
			end
			hbpt_pkg::ST_SQ: begin
				cnt_q  <= cnt_q + 5'd1;
				mm_a_q <= {mm_a_q[30:0], 1'b0};
				mm_r_q <= mm_res;
				if (cnt_last) begin
					acc_q     <= mm_res;
					mm_a_q    <= mm_res;
					mm_b_q    <= mm_res;
					mm_r_q    <= 32'd0;
					i_q       <= i_q + 5'd1;
					verdict_q <= nm1_hit;
				end
			end
			default: begin
			end
		endcase
	end

	// output register, held while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_prime_q <= verdict_q;
			mix_hash_q <= hash_q;
		end
	end

	assign in_stall  = (state_q != hbpt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;
	assign mix_hash  = mix_hash_q;

	// in the exponentiation and squaring states the running remainder and b operand stay reduced
	a_mm_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbpt_pkg::ST_PSQ || state_q == hbpt_pkg::ST_PMUL ||
		 state_q == hbpt_pkg::ST_SQ) |-> (mm_r_q < n_q && mm_b_q < n_q))
		else $error("modular multiplier operand out of range");

	// the strong test only sees odd candidates of at least eleven
	a_odd_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbpt_pkg::ST_CHK || state_q == hbpt_pkg::ST_SQ) |->
		(n_q[0] && n_q >= 32'd11 && s_q != 5'd0 && d_q[0]))
		else $error("strong test entered with a bad split of n-1");

	// a new result only appears from the done state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == hbpt_pkg::ST_DONE)
		else $error("result raised outside the done state");

	// the squaring loop never runs past s-1 squarings
	a_sq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hbpt_pkg::ST_SQ |-> i_q < s_q)
		else $error("squaring loop overran");

endmodule
